>>> design/pwsg_pkg.sv
// shared constants, types and coefficient tables of the waveform sample generator
package pwsg_pkg;

    localparam int TABLE_DEPTH  = 256;
    localparam int PHASE_W      = 16;
    localparam int HORNER_STEPS = 5;
    // x reg, x squared reg, three regs per horner step, product reg, sign reg
    localparam int SIN_LAT      = 4 + 3 * HORNER_STEPS;
    localparam int PHASE_STAGES = PHASE_W;
    localparam int QUO_W        = 12;

    localparam logic [11:0] MV_FULL  = 12'd3300;
    localparam logic [10:0] AMP_MAX  = 11'd2047;
    localparam logic [11:0] MID_CODE = 12'd2048;
    localparam logic [11:0] MAX_CODE = 12'd4095;

    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [15:0] MIX_OFFSET  = 16'd26214;

    localparam logic [2:0] KIND_SINE   = 3'd0;
    localparam logic [2:0] KIND_RAMP   = 3'd1;
    localparam logic [2:0] KIND_SQUARE = 3'd2;
    localparam logic [2:0] KIND_TRI    = 3'd3;
    localparam logic [2:0] KIND_MIX    = 3'd4;

    localparam logic [1:0] CFG_KIND = 2'd0;
    localparam logic [1:0] CFG_LEN  = 2'd1;
    localparam logic [1:0] CFG_MV   = 2'd2;

    typedef struct packed {
        logic [7:0] idx;
        logic       inv;
    } t_tag;

    // taylor divisors, innermost term first
    function automatic logic [6:0] horner_div(input int j);
        logic [6:0] c;
        unique case (j)
            0: c = 7'd110;
            1: c = 7'd72;
            2: c = 7'd42;
            3: c = 7'd20;
            default: c = 7'd6;
        endcase
        return c;
    endfunction

    // floor(2^32 / divisor), estimate is low by at most one
    function automatic logic [29:0] horner_recip(input int j);
        logic [29:0] m;
        unique case (j)
            0: m = 30'd39045157;
            1: m = 30'd59652323;
            2: m = 30'd102261126;
            3: m = 30'd214748364;
            default: m = 30'd715827882;
        endcase
        return m;
    endfunction

endpackage

>>> design/periodic_waveform_sample_generator.sv
// periodic waveform sample generator: sample index in, 12-bit dac code out
//
// input stream carries one sample index per request, output stream one dac
// code per request with index_invalid on tuser. requests leave in order.
// the configuration port writes wave kind, period length and peak-to-peak
// millivolts; write it only while no request is in flight.
// throughput is one request per cycle while the receiver does not stall.
// the output register is the last of 51 stages: 1 input stage, 16 phase
// divider stages (one quotient bit each), 19 sine stages, 1 multiply stage,
// 1 sign/magnitude stage, 12 scaling divider stages and the output register.
// the whole pipeline advances when the output register is empty or taken;
// while the receiver stalls every stage holds and s_axis_tready is low.
// reset clears all valid bits and loads sine, 256 samples and 3300 mv.
module periodic_waveform_sample_generator import pwsg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [11:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] sample_index
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [11:0] dac_code, [15:12] zero
    output logic        m_axis_tuser    // [0] index_invalid
);

    logic [2:0]  r_kind;
    logic [8:0]  r_len_cfg;
    logic [11:0] r_mv_cfg;
    logic [8:0]  n_len;
    logic [11:0] n_mv;
    logic [8:0]  r_len;
    logic [7:0]  r_half;
    logic [22:0] r_amp;
    logic [19:0] r_den;
    logic [19:0] w_den;
    logic        w_lin;
    logic        w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind    <= KIND_SINE;
            r_len_cfg <= 9'(TABLE_DEPTH);
            r_mv_cfg  <= MV_FULL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KIND: r_kind    <= i_cfg_data[2:0];
                CFG_LEN:  r_len_cfg <= i_cfg_data[8:0];
                CFG_MV:   r_mv_cfg  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign n_len = (r_len_cfg > 9'(TABLE_DEPTH)) ? 9'(TABLE_DEPTH) : r_len_cfg;
    assign n_mv  = (r_mv_cfg > MV_FULL) ? MV_FULL : r_mv_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= 9'(TABLE_DEPTH);
            r_half <= 8'(TABLE_DEPTH / 2);
            r_amp  <= 23'(3300 * 2047);
            r_den  <= 20'(3300 * TABLE_DEPTH);
        end else begin
            r_len  <= n_len;
            r_half <= n_len[8:1];
            r_amp  <= 23'(n_mv) * 23'(AMP_MAX);
            r_den  <= 20'(n_len) * 20'(MV_FULL);
        end
    end

    assign w_lin = (r_kind == KIND_RAMP) || (r_kind == KIND_SQUARE) || (r_kind == KIND_TRI);
    assign w_den = w_lin ? r_den : 20'(MV_FULL);

    assign w_adv         = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_adv;

    // input stage
    logic r_a_vld;
    t_tag r_a_tag;
    t_tag n_a_tag;

    assign n_a_tag.idx = s_axis_tdata[7:0];
    assign n_a_tag.inv = ({1'b0, s_axis_tdata[7:0]} >= n_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_adv) begin
            r_a_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_tag <= n_a_tag;
        end
    end

    // phase = floor(idx * 65536 / len), one quotient bit per stage
    logic        r_pd_vld [PHASE_STAGES];
    t_tag        r_pd_tag [PHASE_STAGES];
    logic [8:0]  r_pd_rem [PHASE_STAGES];
    logic [15:0] r_pd_q   [PHASE_STAGES];
    logic        w_pd_vin [PHASE_STAGES];
    t_tag        w_pd_tin [PHASE_STAGES];
    logic [8:0]  w_pd_rin [PHASE_STAGES];
    logic [15:0] w_pd_qin [PHASE_STAGES];

    for (genvar k = 0; k < PHASE_STAGES; k++) begin : g_pd
        logic [9:0] w_dbl;
        logic       w_take;

        if (k == 0) begin : g_first
            assign w_pd_vin[k] = r_a_vld;
            assign w_pd_tin[k] = r_a_tag;
            assign w_pd_rin[k] = {1'b0, r_a_tag.idx};
            assign w_pd_qin[k] = '0;
        end else begin : g_next
            assign w_pd_vin[k] = r_pd_vld[k-1];
            assign w_pd_tin[k] = r_pd_tag[k-1];
            assign w_pd_rin[k] = r_pd_rem[k-1];
            assign w_pd_qin[k] = r_pd_q[k-1];
        end

        assign w_dbl  = {w_pd_rin[k], 1'b0};
        assign w_take = (w_dbl >= {1'b0, r_len});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pd_vld[k] <= 1'b0;
            end else if (w_adv) begin
                r_pd_vld[k] <= w_pd_vin[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_pd_tag[k] <= w_pd_tin[k];
                r_pd_rem[k] <= w_take ? 9'(w_dbl - {1'b0, r_len}) : w_dbl[8:0];
                r_pd_q[k]   <= {w_pd_qin[k][14:0], w_take};
            end
        end
    end

    // sine of the phase and of the phase advanced for the mix
    logic [15:0]        w_ph0;
    logic [15:0]        w_ph1;
    logic signed [17:0] w_sin0;
    logic signed [17:0] w_sin1;

    assign w_ph0 = r_pd_q[PHASE_STAGES-1];
    assign w_ph1 = r_pd_q[PHASE_STAGES-1] + MIX_OFFSET;

    pwsg_sin u_sin0 (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_phase (w_ph0),
        .o_sin   (w_sin0)
    );

    pwsg_sin u_sin1 (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_phase (w_ph1),
        .o_sin   (w_sin1)
    );

    logic r_sd_vld [SIN_LAT];
    t_tag r_sd_tag [SIN_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < SIN_LAT; j++) begin
                r_sd_vld[j] <= 1'b0;
            end
        end else if (w_adv) begin
            r_sd_vld[0] <= r_pd_vld[PHASE_STAGES-1];
            for (int j = 1; j < SIN_LAT; j++) begin
                r_sd_vld[j] <= r_sd_vld[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sd_tag[0] <= r_pd_tag[PHASE_STAGES-1];
            for (int j = 1; j < SIN_LAT; j++) begin
                r_sd_tag[j] <= r_sd_tag[j-1];
            end
        end
    end

    // multiply stage: sine term and linear term by the amplitude
    logic signed [18:0] w_ssel;
    logic signed [23:0] w_amp_s;
    logic signed [11:0] w_i12;
    logic signed [11:0] w_l12;
    logic signed [11:0] w_mul;
    logic               w_low;
    logic               r_m1_vld;
    t_tag               r_m1_tag;
    logic signed [42:0] r_m1_psin;
    logic signed [35:0] r_m1_plin;

    assign w_ssel  = (r_kind == KIND_MIX) ? (19'(w_sin0) + 19'(w_sin1)) : 19'(w_sin0);
    assign w_amp_s = signed'({1'b0, r_amp});
    assign w_i12   = signed'({4'b0, r_sd_tag[SIN_LAT-1].idx});
    assign w_l12   = signed'({3'b0, r_len});
    assign w_low   = (r_sd_tag[SIN_LAT-1].idx < r_half);

    always_comb begin
        unique case (r_kind)
            KIND_RAMP:   w_mul = (w_i12 <<< 1) - w_l12;
            KIND_SQUARE: w_mul = w_low ? w_l12 : -w_l12;
            KIND_TRI:    w_mul = w_low ? ((w_i12 <<< 2) - w_l12)
                                       : (w_l12 + (w_l12 <<< 1) - (w_i12 <<< 2));
            default:     w_mul = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_vld <= 1'b0;
        end else if (w_adv) begin
            r_m1_vld <= r_sd_vld[SIN_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m1_tag  <= r_sd_tag[SIN_LAT-1];
            r_m1_psin <= w_ssel * w_amp_s;
            r_m1_plin <= w_mul * w_amp_s;
        end
    end

    // numerator select, sign and magnitude
    logic signed [42:0] w_num;
    logic signed [42:0] w_abs;
    logic               r_m2_vld;
    t_tag               r_m2_tag;
    logic               r_m2_neg;
    logic [31:0]        r_m2_mag;

    always_comb begin
        unique case (r_kind)
            KIND_SINE:   w_num = r_m1_psin >>> 16;
            KIND_MIX:    w_num = r_m1_psin >>> 17;
            KIND_RAMP,
            KIND_SQUARE,
            KIND_TRI:    w_num = 43'(r_m1_plin);
            default:     w_num = '0;
        endcase
    end

    assign w_abs = w_num[42] ? -w_num : w_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_vld <= 1'b0;
        end else if (w_adv) begin
            r_m2_vld <= r_m1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m2_tag <= r_m1_tag;
            r_m2_neg <= w_num[42];
            r_m2_mag <= {1'b0, w_abs[30:0]};
        end
    end

    // magnitude / denominator, one quotient bit per stage, msb first
    logic        r_dv_vld [QUO_W];
    t_tag        r_dv_tag [QUO_W];
    logic        r_dv_neg [QUO_W];
    logic [31:0] r_dv_rem [QUO_W];
    logic [11:0] r_dv_q   [QUO_W];
    logic        w_dv_vin [QUO_W];
    t_tag        w_dv_tin [QUO_W];
    logic        w_dv_nin [QUO_W];
    logic [31:0] w_dv_rin [QUO_W];
    logic [11:0] w_dv_qin [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_dv
        localparam int SHIFT = QUO_W - 1 - k;
        logic [31:0] w_dsh;
        logic        w_take;

        if (k == 0) begin : g_first
            assign w_dv_vin[k] = r_m2_vld;
            assign w_dv_tin[k] = r_m2_tag;
            assign w_dv_nin[k] = r_m2_neg;
            assign w_dv_rin[k] = r_m2_mag;
            assign w_dv_qin[k] = '0;
        end else begin : g_next
            assign w_dv_vin[k] = r_dv_vld[k-1];
            assign w_dv_tin[k] = r_dv_tag[k-1];
            assign w_dv_nin[k] = r_dv_neg[k-1];
            assign w_dv_rin[k] = r_dv_rem[k-1];
            assign w_dv_qin[k] = r_dv_q[k-1];
        end

        assign w_dsh  = 32'(w_den) << SHIFT;
        assign w_take = (w_dv_rin[k] >= w_dsh);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[k] <= 1'b0;
            end else if (w_adv) begin
                r_dv_vld[k] <= w_dv_vin[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dv_tag[k] <= w_dv_tin[k];
                r_dv_neg[k] <= w_dv_nin[k];
                r_dv_rem[k] <= w_take ? (w_dv_rin[k] - w_dsh) : w_dv_rin[k];
                r_dv_q[k]   <= {w_dv_qin[k][10:0], w_take};
            end
        end
    end

    // floor toward minus infinity, offset, clamp
    logic [11:0]        w_q;
    logic               w_rnz;
    logic signed [13:0] w_qs;
    logic signed [13:0] w_code;
    logic [11:0]        w_clip;
    logic [11:0]        n_out_code;
    logic               r_out_vld;
    logic [11:0]        r_out_code;
    logic               r_out_inv;

    assign w_q   = r_dv_q[QUO_W-1];
    assign w_rnz = |r_dv_rem[QUO_W-1];
    assign w_qs  = signed'({2'b00, w_q});
    assign w_code = r_dv_neg[QUO_W-1]
                  ? (14'sd2048 - w_qs - signed'({13'b0, w_rnz}))
                  : (14'sd2048 + w_qs);

    always_comb begin
        priority if (w_code < 14'sd0) begin
            w_clip = '0;
        end else if (w_code > signed'({2'b00, MAX_CODE})) begin
            w_clip = MAX_CODE;
        end else begin
            w_clip = w_code[11:0];
        end
    end

    assign n_out_code = r_dv_tag[QUO_W-1].inv ? MID_CODE : w_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_dv_vld[QUO_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_code <= n_out_code;
            r_out_inv  <= r_dv_tag[QUO_W-1].inv;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {4'b0000, r_out_code};
    assign m_axis_tuser  = r_out_inv;

    a_inv_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[11:0] == MID_CODE))
        else $error("invalid index must give the mid code");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(r_dv_vld[QUO_W-1]))
        else $error("pipeline moved during an output stall");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_a_vld)
        else $error("accepted request did not enter the input stage");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

>>> design/pwsg_sin.sv
// pipelined q.16 sine of a 16-bit phase, quadrant fold plus horner taylor series
module pwsg_sin import pwsg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [15:0]        i_phase,
    output logic signed [17:0] o_sin
);

    logic [14:0] w_r;
    logic [45:0] w_xp;
    logic [30:0] r_x1;
    logic        r_n1;
    logic [61:0] w_sq;
    logic [30:0] r_s2_x;
    logic [31:0] r_s2_x2;
    logic        r_s2_n;

    logic [30:0] w_tin  [HORNER_STEPS];
    logic [30:0] w_xin  [HORNER_STEPS];
    logic [31:0] w_x2in [HORNER_STEPS];
    logic        w_nin  [HORNER_STEPS];

    logic [31:0] r_hm_v  [HORNER_STEPS];
    logic [30:0] r_hm_x  [HORNER_STEPS];
    logic [31:0] r_hm_x2 [HORNER_STEPS];
    logic        r_hm_n  [HORNER_STEPS];
    logic [29:0] r_hr_qe [HORNER_STEPS];
    logic [31:0] r_hr_v  [HORNER_STEPS];
    logic [30:0] r_hr_x  [HORNER_STEPS];
    logic [31:0] r_hr_x2 [HORNER_STEPS];
    logic        r_hr_n  [HORNER_STEPS];
    logic [30:0] r_ht    [HORNER_STEPS];
    logic [30:0] r_hc_x  [HORNER_STEPS];
    logic [31:0] r_hc_x2 [HORNER_STEPS];
    logic        r_hc_n  [HORNER_STEPS];

    logic [61:0]        w_yp;
    logic [16:0]        r_y;
    logic               r_yn;
    logic signed [17:0] w_ys;
    logic signed [17:0] r_out;

    // fold into the first quadrant, odd quadrants mirror
    assign w_r  = i_phase[14] ? (15'h4000 - {1'b0, i_phase[13:0]}) : {1'b0, i_phase[13:0]};
    assign w_xp = 46'(w_r) * 46'(HALF_PI_Q30);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x1 <= w_xp[44:14];
            r_n1 <= i_phase[15];
        end
    end

    assign w_sq = 62'(r_x1) * 62'(r_x1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_x2 <= w_sq[61:30];
            r_s2_x  <= r_x1;
            r_s2_n  <= r_n1;
        end
    end

    for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_h
        logic [62:0] w_prod;
        logic [61:0] w_rp;
        logic [31:0] w_qc;
        logic [31:0] w_rr;
        logic [30:0] w_q;

        if (j == 0) begin : g_first
            assign w_tin[j]  = ONE_Q30;
            assign w_xin[j]  = r_s2_x;
            assign w_x2in[j] = r_s2_x2;
            assign w_nin[j]  = r_s2_n;
        end else begin : g_next
            assign w_tin[j]  = r_ht[j-1];
            assign w_xin[j]  = r_hc_x[j-1];
            assign w_x2in[j] = r_hc_x2[j-1];
            assign w_nin[j]  = r_hc_n[j-1];
        end

        assign w_prod = 63'(w_x2in[j]) * 63'(w_tin[j]);
        assign w_rp   = 62'(r_hm_v[j]) * 62'(horner_recip(j));
        assign w_qc   = 32'(r_hr_qe[j]) * 32'(horner_div(j));
        assign w_rr   = r_hr_v[j] - w_qc;
        // reciprocal estimate may be one short
        assign w_q    = 31'(r_hr_qe[j]) + 31'(w_rr >= 32'(horner_div(j)));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_hm_v[j]  <= w_prod[61:30];
                r_hm_x[j]  <= w_xin[j];
                r_hm_x2[j] <= w_x2in[j];
                r_hm_n[j]  <= w_nin[j];

                r_hr_qe[j] <= w_rp[61:32];
                r_hr_v[j]  <= r_hm_v[j];
                r_hr_x[j]  <= r_hm_x[j];
                r_hr_x2[j] <= r_hm_x2[j];
                r_hr_n[j]  <= r_hm_n[j];

                r_ht[j]    <= ONE_Q30 - w_q;
                r_hc_x[j]  <= r_hr_x[j];
                r_hc_x2[j] <= r_hr_x2[j];
                r_hc_n[j]  <= r_hr_n[j];
            end
        end
    end

    assign w_yp = 62'(r_hc_x[HORNER_STEPS-1]) * 62'(r_ht[HORNER_STEPS-1]);
    assign w_ys = signed'({1'b0, r_y});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y   <= w_yp[60:44];
            r_yn  <= r_hc_n[HORNER_STEPS-1];
            r_out <= r_yn ? -w_ys : w_ys;
        end
    end

    assign o_sin = r_out;

endmodule
